>>> hw/rtl/cfks_pkg.sv
package cfks_pkg;

	localparam int FRAC_BITS       = 30;
	localparam int MAX_ORDER_LIMIT = 63;

	localparam int VALUE_W = 32;
	localparam int ORDER_W = 6;
	localparam int TWOX_W  = VALUE_W + 1;

	// highest order one run may reach
	localparam int ORDER_CAP = (MAX_ORDER_LIMIT < 63) ? MAX_ORDER_LIMIT : 63;

	// magnitude widths for the serial multiplier
	localparam int MAG_A_W = TWOX_W - 1;
	localparam int MAG_B_W = VALUE_W - 1;
	localparam int PROD_W  = MAG_A_W + MAG_B_W;
	localparam int RND_W   = PROD_W - FRAC_BITS;
	localparam int RES_W   = RND_W + 1;
	localparam int STEP_W  = $clog2(MAG_B_W);

	localparam logic signed [VALUE_W-1:0] ONE_FIX = VALUE_W'(64'd1 << FRAC_BITS);

	function automatic logic signed [VALUE_W-1:0] clamp_one(input logic signed [RES_W:0] v);
		logic signed [RES_W:0] one_w;
		one_w = (RES_W+1)'(ONE_FIX);
		if (v > one_w)
			return ONE_FIX;
		else if (v < -one_w)
			return -ONE_FIX;
		else
			return VALUE_W'(v);
	endfunction

endpackage

>>> hw/rtl/cfks_mul.sv
module cfks_mul import cfks_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [TWOX_W-1:0]   op_a,
	input  logic signed [VALUE_W-1:0]  op_b,
	output logic                       done,
	output logic signed [RES_W-1:0]    result
);

	logic [MAG_A_W-1:0] ma_q;
	logic [MAG_B_W-1:0] mb_q;
	logic [MAG_A_W-1:0] hi_q;
	logic [MAG_B_W-1:0] lo_q;
	logic               neg_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               rnd_q;
	logic               done_q;
	logic signed [RES_W-1:0] res_q;

	logic [TWOX_W-1:0]  abs_a;
	logic [VALUE_W-1:0] abs_b;
	logic [MAG_A_W:0]   sum;
	logic [PROD_W-1:0]  prod;
	logic [RND_W-1:0]   rnd;

	assign abs_a = op_a[TWOX_W-1] ? TWOX_W'(-op_a) : TWOX_W'(op_a);
	assign abs_b = op_b[VALUE_W-1] ? VALUE_W'(-op_b) : VALUE_W'(op_b);

	// one multiplier bit per cycle, low product bits shift out into lo_q
	assign sum  = {1'b0, hi_q} + (mb_q[0] ? {1'b0, ma_q} : '0);
	assign prod = {hi_q, lo_q};
	// round half away from zero on the magnitude
	assign rnd  = prod[PROD_W-1:FRAC_BITS] + RND_W'(prod[FRAC_BITS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			neg_q  <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			rnd_q  <= 1'b0;
			if (start) begin
				ma_q   <= abs_a[MAG_A_W-1:0];
				mb_q   <= abs_b[MAG_B_W-1:0];
				neg_q  <= op_a[TWOX_W-1] ^ op_b[VALUE_W-1];
				hi_q   <= '0;
				lo_q   <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hi_q <= sum[MAG_A_W:1];
				lo_q <= {sum[0], lo_q[MAG_B_W-1:1]};
				mb_q <= mb_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MAG_B_W - 1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				res_q  <= neg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
				done_q <= 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> hw/rtl/chebyshev_first_kind_sequence_unit.sv
// Chebyshev polynomial sequence unit, first kind.
// Input channel: arg_x (signed Q2.30) with in_valid/in_stall; a transaction
// happens when in_valid is high and in_stall is low. in_stall is high while
// a run is in progress, so one argument is worked on at a time.
// Output channel: poly_value, order_index, last_of_run with out_valid and
// out_stall. For each argument the unit emits T0..Tn, n = max_order capped
// to the order limit; the result with order n has last_of_run set.
// Config channel: max_order with cfg_valid/cfg_ready, always ready; write
// it only between runs.
// Sequence: the input transaction loads T0 = 1.0, which the EMIT state puts
// into the output register, followed by T1 = x. Each higher order takes one
// pass of the bit-serial multiplier, a rounding step in the multiplier, a
// subtract-and-saturate step and an emit step. After the emit of order n the
// sequencer returns to idle and the next argument is taken.
// A stalled result sits in the output register and the sequence waits.
// Reset clears max_order to 0, empties the output register and returns the
// sequencer to idle.
module chebyshev_first_kind_sequence_unit import cfks_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] arg_x,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] poly_value,
	output logic [ORDER_W-1:0]        order_index,
	output logic                      last_of_run,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ORDER_W-1:0]        max_order
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_MUL
	} state_t;

	state_t                     state_q;
	logic [ORDER_W-1:0]         max_order_q;
	logic [ORDER_W-1:0]         k_q;
	logic [ORDER_W-1:0]         n_q;
	logic signed [VALUE_W-1:0]  x_q;
	logic signed [TWOX_W-1:0]   twox_q;
	logic signed [VALUE_W-1:0]  cur_q;
	logic signed [VALUE_W-1:0]  prev2_q;
	logic                       out_valid_q;
	logic signed [VALUE_W-1:0]  poly_value_q;
	logic [ORDER_W-1:0]         order_index_q;
	logic                       last_of_run_q;

	logic                       out_free;
	logic                       mul_start;
	logic                       mul_done;
	logic signed [RES_W-1:0]    mul_res;
	logic signed [VALUE_W-1:0]  x_sat;
	logic [ORDER_W-1:0]         n_eff;
	logic signed [RES_W:0]      diff;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign x_sat = clamp_one((RES_W+1)'(arg_x));
	assign n_eff = (int'(max_order_q) > ORDER_CAP) ? ORDER_W'(ORDER_CAP) : max_order_q;
	assign diff  = (RES_W+1)'(mul_res) - (RES_W+1)'(prev2_q);

	assign mul_start = (state_q == ST_EMIT) && out_free && (k_q != n_q) && (k_q != '0);

	cfks_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (twox_q),
		.op_b   (cur_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_order_q   <= '0;
			k_q           <= '0;
			n_q           <= '0;
			x_q           <= '0;
			twox_q        <= '0;
			cur_q         <= '0;
			prev2_q       <= '0;
			out_valid_q   <= 1'b0;
			poly_value_q  <= '0;
			order_index_q <= '0;
			last_of_run_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_order_q <= max_order;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q     <= x_sat;
						twox_q  <= (TWOX_W)'(x_sat) + (TWOX_W)'(x_sat);
						k_q     <= '0;
						n_q     <= n_eff;
						cur_q   <= ONE_FIX;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						poly_value_q  <= cur_q;
						order_index_q <= k_q;
						last_of_run_q <= (k_q == n_q);
						prev2_q       <= poly_value_q;
						// prev2 now holds T(k-1), cur_q still T(k) until the product lands
						if (k_q == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							if (k_q == '0) begin
								cur_q <= x_q;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						cur_q   <= clamp_one(diff);
						state_q <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign poly_value  = poly_value_q;
	assign order_index = order_index_q;
	assign last_of_run = last_of_run_q;

endmodule

>>> hw/rtl/cfks_chk.sv
module cfks_chk import cfks_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [VALUE_W-1:0] poly_value,
	input logic [ORDER_W-1:0]        order_index,
	input logic                      last_of_run
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(poly_value)
			&& $stable(order_index) && $stable(last_of_run))
		else $error("stalled result changed");

	// a run blocks further arguments
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not blocked after transaction");

	// every run starts with T0 = 1.0
	a_t0_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && order_index == '0 |-> poly_value == ONE_FIX)
		else $error("order zero value is not one");

	// results stay saturated
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (poly_value <= ONE_FIX) && (poly_value >= -ONE_FIX))
		else $error("result outside saturation range");

endmodule

bind chebyshev_first_kind_sequence_unit cfks_chk u_cfks_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.poly_value  (poly_value),
	.order_index (order_index),
	.last_of_run (last_of_run)
);

>>> dv/tb_top.sv
module tb_top;
	import cfks_pkg::*;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [ORDER_W-1:0]        order;
		logic                      last;
	} cheb_term_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] arg_x;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [VALUE_W-1:0] poly_value;
	logic [ORDER_W-1:0]        order_index;
	logic                      last_of_run;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [ORDER_W-1:0]        max_order;

	cheb_term_t         pending_terms[$];
	int                 error_count = 0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 recv_hold = 0;

	// predictor copy of register and recurrence state
	logic [ORDER_W-1:0] order_setting = '0;
	longint             term_prev = 0;
	longint             term_prev2 = 0;
	longint             twice_x = 0;
	int                 last_order = 0;

	chebyshev_first_kind_sequence_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.arg_x       (arg_x),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.poly_value  (poly_value),
		.order_index (order_index),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.max_order   (max_order)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#40_000_000;
		$display("FAIL chebyshev_first_kind_sequence_unit");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 50)
			$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic longint clamp_unit(input longint v);
		longint one;
		one = longint'(ONE_FIX);
		if (v > one)
			return one;
		if (v < -one)
			return -one;
		return v;
	endfunction

	// (a*b) >> FRAC_BITS on magnitudes, halfway rounds away from zero
	function automatic longint round_mul(input longint a, input longint b);
		longint unsigned ma;
		longint unsigned mb;
		longint unsigned r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		r = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
	endfunction

	function automatic void predict_run(input logic signed [VALUE_W-1:0] x_in);
		longint     x;
		longint     cur;
		int         n;
		cheb_term_t t;
		n = (order_setting > ORDER_CAP) ? ORDER_CAP : order_setting;
		x = clamp_unit(longint'(x_in));
		twice_x = x + x;
		for (int k = 0; k <= n; k++) begin
			if (k == 0)
				cur = longint'(ONE_FIX);
			else if (k == 1)
				cur = x;
			else
				cur = clamp_unit(round_mul(twice_x, term_prev) - term_prev2);
			term_prev2 = term_prev;
			term_prev = cur;
			last_order = k;
			t.value = cur[VALUE_W-1:0];
			t.order = k[ORDER_W-1:0];
			t.last = (k == n);
			pending_terms.push_back(t);
		end
	endfunction

	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_stall <= 1'b1;
			recv_hold = recv_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_terms
		cheb_term_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_terms.size() == 0) begin
				report_mismatch($sformatf("unexpected result order %0d value %0d",
					order_index, poly_value));
			end else begin
				want = pending_terms.pop_front();
				if (poly_value !== want.value)
					report_mismatch($sformatf("order %0d value %0d, want %0d",
						want.order, poly_value, want.value));
				if (order_index !== want.order)
					report_mismatch($sformatf("order index %0d, want %0d",
						order_index, want.order));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("order %0d last flag %b, want %b",
						want.order, last_of_run, want.last));
			end
		end
	end

	// entered and left at a falling edge; valid stays up for a following transaction
	task automatic send_arg(input logic signed [VALUE_W-1:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		arg_x <= x;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_run(x);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_terms.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_max_order(input logic [ORDER_W-1:0] n);
		wait_idle();
		max_order <= n;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		order_setting = n;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [VALUE_W-1:0] random_arg();
		longint v;
		case ($urandom_range(9))
			0: v = longint'($urandom);
			1: v = longint'(ONE_FIX) - longint'($urandom_range(0, 512)) + 256;
			2: v = -longint'(ONE_FIX) + longint'($urandom_range(0, 512)) - 256;
			3: v = longint'($urandom_range(0, 131072)) - 65536;
			default: v = longint'($urandom_range(0, 32'h8000_0000)) - longint'(ONE_FIX);
		endcase
		return v[VALUE_W-1:0];
	endfunction

	task automatic test_directed();
		set_max_order(0);
		send_arg(0);
		send_arg(ONE_FIX);
		send_arg(-ONE_FIX);
		set_max_order(63);
		send_arg(ONE_FIX);
		send_arg(-ONE_FIX);
		send_arg(32'sh7fff_ffff);
		send_arg(32'sh8000_0000);
		set_max_order(6);
		send_arg(0);
		send_arg(32'sd16384);
		send_arg(-32'sd16384);
		send_arg(ONE_FIX + 1);
		send_arg(-ONE_FIX - 1);
		send_arg(1);
		send_arg(-1);
		send_arg(ONE_FIX >>> 1);
		send_arg(-(ONE_FIX >>> 1));
		send_arg(32'sh2aaa_aaab);
		send_arg(-32'sh2aaa_aaab);
		set_max_order(1);
		send_arg(32'sh1234_5678);
		send_arg(32'shedcb_a988);
		set_max_order(2);
		send_arg(32'sh3fff_ffff);
		send_arg(-32'sh3fff_ffff);
	endtask

	task automatic test_random_args(input int count);
		int                 sent;
		int                 run_len;
		logic [ORDER_W-1:0] n;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(9))
				0: n = ORDER_W'(63);
				1: n = ORDER_W'($urandom_range(8, 62));
				2: n = '0;
				default: n = ORDER_W'($urandom_range(1, 7));
			endcase
			run_len = (n > 15) ? $urandom_range(1, 3) : $urandom_range(6, 16);
			set_max_order(n);
			repeat (run_len) begin
				send_arg(random_arg());
				sent++;
			end
		end
	endtask

	// receiver holds off while arguments keep coming, so the input backs up
	task automatic test_backpressure();
		set_max_order(4);
		@(posedge clk);
		recv_hold = 300;
		@(negedge clk);
		repeat (6) send_arg(random_arg());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		arg_x = '0;
		cfg_valid = 1'b0;
		max_order = '0;
		out_stall = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 8;
		recv_idle_pct = 81;
		test_directed();
		test_random_args(110);

		send_idle_pct = 81;
		recv_idle_pct = 8;
		test_random_args(110);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_args(110);

		wait_idle();
		repeat (40) @(negedge clk);
		if (error_count == 0)
			$display("PASS chebyshev_first_kind_sequence_unit");
		else
			$display("FAIL chebyshev_first_kind_sequence_unit");
		$finish;
	end
endmodule
